FILE: rtl/core/lhtm_pkg.sv
// shared types and constants of the lock hold timeout monitor
package lhtm_pkg;

  // table size and derived widths
  localparam int MAX_LOCKS = 16;
  localparam int IDX_W     = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
  localparam int CNT_W     = $clog2(MAX_LOCKS + 1);

  // fixed field widths
  localparam int KEY_W    = 32;
  localparam int HOLDER_W = 8;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 4;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIMEOUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE = 8'd1;
  localparam logic [TIME_W-1:0]    HOLD_TIMEOUT_RST = 32'd5000;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_ACQUIRE  = 2'd1,
    CMD_RELEASE  = 2'd2,
    CMD_CHECK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNTRACKED = 2'd1,
    ST_FULL      = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_t;

  // input word
  typedef struct packed {
    cmd_t                cmd;
    logic [KEY_W-1:0]    lock_handle;
    logic [HOLDER_W-1:0] holder_id;
    logic [TIME_W-1:0]   time_now;
  } item_t;

  // result word
  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [HOLDER_W-1:0] expired_holder;
    logic [TIME_W-1:0]   hold_time;
  } result_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic                held;
    logic [HOLDER_W-1:0] holder;
    logic [TIME_W-1:0]   acq_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // configuration seen by the engine
  typedef struct packed {
    logic [TIME_W-1:0] hold_timeout;
    logic              check_enable;
  } cfg_t;

endpackage

FILE: rtl/core/lhtm_ram.sv
// generic single write port ram with one registered read port
module lhtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/lhtm_engine.sv
// command sequencer: appends entries and scans the lock table one entry a cycle
module lhtm_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  lhtm_pkg::item_t        item,
  input  lhtm_pkg::cfg_t         cfg,
  output logic                   busy,
  output logic                   result_valid,
  output lhtm_pkg::result_t      result,
  output logic                   ram_wr_en,
  output logic [lhtm_pkg::IDX_W-1:0] ram_wr_addr,
  output lhtm_pkg::entry_t       ram_wr_data,
  output logic [lhtm_pkg::IDX_W-1:0] ram_rd_addr,
  input  lhtm_pkg::entry_t       ram_rd_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                         state;
  lhtm_pkg::item_t                item_q;
  logic [lhtm_pkg::IDX_W-1:0]     idx;
  logic [lhtm_pkg::CNT_W-1:0]     entry_count;

  logic                           accept;
  logic                           has_room;
  logic                           is_last;
  logic                           key_match;
  logic [lhtm_pkg::TIME_W-1:0]    held_for;
  logic                           expired;

  assign busy     = (state != S_IDLE);
  assign accept   = start && (state == S_IDLE);
  assign has_room = (entry_count < lhtm_pkg::CNT_W'(lhtm_pkg::MAX_LOCKS));

  // compare logic on the entry read in the previous cycle
  assign is_last   = ((lhtm_pkg::CNT_W'(idx) + lhtm_pkg::CNT_W'(1)) == entry_count);
  assign key_match = (ram_rd_data.key == item_q.lock_handle);
  assign held_for  = item_q.time_now - ram_rd_data.acq_time;
  assign expired   = ram_rd_data.held && (held_for > cfg.hold_timeout);

  // memory access: the next entry is fetched while the current one is judged;
  // writes land before any later item can issue its first read
  always_comb begin
    ram_rd_addr = (state == S_IDLE) ? '0 : idx + lhtm_pkg::IDX_W'(1);
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx;
    ram_wr_data = '0;
    if (state == S_IDLE) begin
      ram_wr_en            = accept && (item.cmd == lhtm_pkg::CMD_REGISTER) && has_room;
      ram_wr_addr          = lhtm_pkg::IDX_W'(entry_count);
      ram_wr_data.key      = item.lock_handle;
    end else begin
      ram_wr_en            = (item_q.cmd != lhtm_pkg::CMD_CHECK) && key_match;
      ram_wr_data.key      = item_q.lock_handle;
      if (item_q.cmd == lhtm_pkg::CMD_ACQUIRE) begin
        ram_wr_data.held     = 1'b1;
        ram_wr_data.holder   = item_q.holder_id;
        ram_wr_data.acq_time = item_q.time_now;
      end
    end
  end

  // sequencer and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_q <= item;
            idx    <= '0;
            case (item.cmd)
              lhtm_pkg::CMD_REGISTER: begin
                result_valid <= 1'b1;
                if (has_room) begin
                  result      <= '{status: lhtm_pkg::ST_OK,
                                   slot: lhtm_pkg::SLOT_W'(entry_count),
                                   expired_holder: '0, hold_time: '0};
                  entry_count <= entry_count + lhtm_pkg::CNT_W'(1);
                end else begin
                  result <= '{status: lhtm_pkg::ST_FULL, slot: '0, expired_holder: '0,
                              hold_time: '0};
                end
              end
              lhtm_pkg::CMD_ACQUIRE, lhtm_pkg::CMD_RELEASE: begin
                if (entry_count == '0) begin
                  result_valid <= 1'b1;
                  result       <= '{status: lhtm_pkg::ST_UNTRACKED, slot: '0,
                                    expired_holder: '0, hold_time: '0};
                end else begin
                  state <= S_SCAN;
                end
              end
              lhtm_pkg::CMD_CHECK: begin
                if (!cfg.check_enable || (entry_count == '0)) begin
                  result_valid <= 1'b1;
                  result       <= '{status: lhtm_pkg::ST_OK, slot: '0, expired_holder: '0,
                                    hold_time: '0};
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                result_valid <= 1'b1;
                result       <= '{status: lhtm_pkg::ST_OK, slot: '0, expired_holder: '0,
                                  hold_time: '0};
              end
            endcase
          end
        end
        S_SCAN: begin
          if (item_q.cmd == lhtm_pkg::CMD_CHECK) begin
            // first held entry past the timeout
            if (expired) begin
              result_valid <= 1'b1;
              state        <= S_IDLE;
              result       <= '{status: lhtm_pkg::ST_TIMEOUT,
                                slot: lhtm_pkg::SLOT_W'(idx),
                                expired_holder: ram_rd_data.holder,
                                hold_time: held_for};
            end else if (is_last) begin
              result_valid <= 1'b1;
              state        <= S_IDLE;
              result       <= '{status: lhtm_pkg::ST_OK, slot: '0, expired_holder: '0,
                                hold_time: '0};
            end else begin
              idx <= idx + lhtm_pkg::IDX_W'(1);
            end
          end else begin
            // first entry with a matching handle
            if (key_match) begin
              result_valid <= 1'b1;
              state        <= S_IDLE;
              result       <= '{status: lhtm_pkg::ST_OK, slot: lhtm_pkg::SLOT_W'(idx),
                                expired_holder: '0, hold_time: '0};
            end else if (is_last) begin
              result_valid <= 1'b1;
              state        <= S_IDLE;
              result       <= '{status: lhtm_pkg::ST_UNTRACKED, slot: '0,
                                expired_holder: '0, hold_time: '0};
            end else begin
              idx <= idx + lhtm_pkg::IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks on the sequencer
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= lhtm_pkg::CNT_W'(lhtm_pkg::MAX_LOCKS))
    else $error("entry count beyond table size");

  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (lhtm_pkg::CNT_W'(idx) < entry_count))
    else $error("scan index outside filled entries");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == S_IDLE))
    else $error("result strobe while still scanning");

  a_register_reply: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.cmd == lhtm_pkg::CMD_REGISTER)) |=> result_valid)
    else $error("register word not answered in the next cycle");

  a_write_match: assert property (@(posedge clk) disable iff (rst)
    (ram_wr_en && (state == S_SCAN)) |=> (result_valid && (result.status == lhtm_pkg::ST_OK)))
    else $error("table written without an ok result");

endmodule

FILE: rtl/core/lock_hold_timeout_monitor_core.sv
// top level of the lock hold timeout monitor: configuration registers and table memory
//
// Usage
//   Command channel: drive item and raise start; the word is taken at a rising edge with
//   start high and busy low. Each command gives exactly one result word on result,
//   flagged by result_valid for one cycle; the receiver cannot stall it.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
//   hold_timeout, index 1 is check_enable (bit 0), other indexes are ignored.
//   cfg_ready is always high; write only while no command is outstanding.
// Command handling
//   Register, any command on an empty table and a check with checks disabled answer in
//   the cycle after acceptance, and the block is free again at once.
//   Acquire, release and check walk the table through the single read port of the entry
//   memory, one entry a cycle, and answer on the first hit or after the last filled entry;
//   busy is high until the cycle of the answer. A full table holds 16 entries.
// Reset
//   rst (synchronous) empties the table and restores hold_timeout 5000, check_enable 1.
//   Entries are only judged below the fill count, so no clearing pass is needed.
module lock_hold_timeout_monitor_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  lhtm_pkg::item_t                 item,
  output logic                            busy,
  output logic                            result_valid,
  output lhtm_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lhtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lhtm_pkg::CFG_DATA_W-1:0] cfg_data
);

  lhtm_pkg::cfg_t                 cfg;
  logic                           ram_wr_en;
  logic [lhtm_pkg::IDX_W-1:0]     ram_wr_addr;
  lhtm_pkg::entry_t               ram_wr_data;
  logic [lhtm_pkg::IDX_W-1:0]     ram_rd_addr;
  lhtm_pkg::entry_t               ram_rd_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_timeout <= lhtm_pkg::HOLD_TIMEOUT_RST;
      cfg.check_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lhtm_pkg::REG_HOLD_TIMEOUT: cfg.hold_timeout <= cfg_data[lhtm_pkg::TIME_W-1:0];
        lhtm_pkg::REG_CHECK_ENABLE: cfg.check_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  lhtm_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .cfg          (cfg),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  // lock table memory
  lhtm_ram #(
    .WIDTH (lhtm_pkg::ENTRY_W),
    .DEPTH (lhtm_pkg::MAX_LOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
